// File: sv/irc_line_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// IRC line tokenizer assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef IRC_LINE_TOKENIZER_MACROS_SVH
`define IRC_LINE_TOKENIZER_MACROS_SVH

// same-cycle implication
`define IRC_TOK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IRC_TOK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/irc_tok_pkg.sv
// ----------------------------------------------------------------------------
// IRC line tokenizer package
// Event codes, character constants and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package irc_tok_pkg;

  localparam int MAX_PARAMS = 15;
  localparam logic [3:0] PARAM_CAP = (MAX_PARAMS > 15) ? 4'd15 : 4'(MAX_PARAMS);

  localparam logic [2:0] EV_DATA    = 3'd0;
  localparam logic [2:0] EV_END     = 3'd1;
  localparam logic [2:0] EV_DISCARD = 3'd2;
  localparam logic [2:0] EV_OK      = 3'd3;
  localparam logic [2:0] EV_ERR     = 3'd4;

  localparam logic [1:0] KIND_PREFIX  = 2'd0;
  localparam logic [1:0] KIND_COMMAND = 2'd1;
  localparam logic [1:0] KIND_MIDDLE  = 2'd2;
  localparam logic [1:0] KIND_TRAIL   = 2'd3;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] char_out;
    logic [1:0] field_kind;
    logic [3:0] param_index;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// File: sv/irc_tok_step.sv
// ----------------------------------------------------------------------------
// IRC tokenizer step
// Line-parse state and the results one byte produces (zero, one or two).
// ----------------------------------------------------------------------------
`default_nettype none

module irc_tok_step (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              link_closed,
  input  wire logic              commit,
  output logic [1:0]             res_cnt,
  output irc_tok_pkg::res_t      res0,
  output irc_tok_pkg::res_t      res1
);
  import irc_tok_pkg::*;

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_PREFIX  = 3'd1;
  localparam logic [2:0] PH_COMMAND = 3'd2;
  localparam logic [2:0] PH_PARAM   = 3'd3;
  localparam logic [2:0] PH_TRAIL   = 3'd4;

  logic [2:0] phase_r, phase_nxt, ph;
  logic [3:0] pcnt_r, pcnt_nxt;
  logic       fopen_r, fopen_nxt;
  logic [1:0] kind_cur;
  logic [3:0] idx_cur;

  always_comb begin
    ph = (phase_r > PH_TRAIL) ? PH_START : phase_r;
    case (ph)
      PH_PREFIX:  kind_cur = KIND_PREFIX;
      PH_COMMAND: kind_cur = KIND_COMMAND;
      PH_PARAM:   kind_cur = KIND_MIDDLE;
      default:    kind_cur = KIND_TRAIL;
    endcase
    idx_cur = (ph == PH_PARAM || ph == PH_TRAIL) ? pcnt_r : 4'd0;
  end

  always_comb begin
    phase_nxt = phase_r;
    pcnt_nxt  = pcnt_r;
    fopen_nxt = fopen_r;
    res_cnt   = 2'd0;
    res0      = '0;
    res1      = '0;
    if (link_closed || rx_byte == CH_LF) begin
      phase_nxt = PH_START;
      pcnt_nxt  = 4'd0;
      fopen_nxt = 1'b0;
      if (ph != PH_START) begin
        res0    = '{EV_END, 8'd0, kind_cur, idx_cur, 1'b0};
        res1    = '{(link_closed ? EV_ERR : EV_OK), 8'd0, 2'd0, 4'd0, 1'b1};
        res_cnt = 2'd2;
      end else begin
        res0    = '{(link_closed ? EV_ERR : EV_OK), 8'd0, 2'd0, 4'd0, 1'b1};
        res_cnt = 2'd1;
      end
    end else if (rx_byte != CH_CR) begin
      case (ph)
        PH_PREFIX: begin
          res_cnt = 2'd1;
          if (rx_byte == CH_SPACE) begin
            res0      = '{EV_END, 8'd0, KIND_PREFIX, 4'd0, 1'b1};
            phase_nxt = PH_COMMAND;
            fopen_nxt = 1'b0;
          end else begin
            res0      = '{EV_DATA, rx_byte, KIND_PREFIX, 4'd0, 1'b1};
            fopen_nxt = 1'b1;
          end
        end
        PH_COMMAND: begin
          res_cnt = 2'd1;
          if (rx_byte == CH_SPACE) begin
            res0      = '{EV_END, 8'd0, KIND_COMMAND, 4'd0, 1'b1};
            phase_nxt = PH_PARAM;
            pcnt_nxt  = 4'd0;
            fopen_nxt = 1'b0;
          end else begin
            res0      = '{EV_DATA, rx_byte, KIND_COMMAND, 4'd0, 1'b1};
            fopen_nxt = 1'b1;
          end
        end
        PH_PARAM: begin
          if (rx_byte == CH_SPACE) begin
            res0      = '{EV_END, 8'd0, KIND_MIDDLE, pcnt_r, 1'b1};
            res_cnt   = 2'd1;
            // index saturates: overflow marker
            if (pcnt_r < PARAM_CAP) pcnt_nxt = pcnt_r + 4'd1;
            fopen_nxt = 1'b0;
          end else if (rx_byte == CH_COLON) begin
            // discard only if the parameter already gathered bytes
            if (fopen_r) begin
              res0    = '{EV_DISCARD, 8'd0, KIND_MIDDLE, pcnt_r, 1'b1};
              res_cnt = 2'd1;
            end
            phase_nxt = PH_TRAIL;
            fopen_nxt = 1'b0;
          end else begin
            res0      = '{EV_DATA, rx_byte, KIND_MIDDLE, pcnt_r, 1'b1};
            res_cnt   = 2'd1;
            fopen_nxt = 1'b1;
          end
        end
        PH_TRAIL: begin
          res0      = '{EV_DATA, rx_byte, KIND_TRAIL, pcnt_r, 1'b1};
          res_cnt   = 2'd1;
          fopen_nxt = 1'b1;
        end
        default: begin
          pcnt_nxt  = 4'd0;
          fopen_nxt = 1'b0;
          if (rx_byte == CH_COLON) begin
            phase_nxt = PH_PREFIX;
          end else if (rx_byte == CH_SPACE) begin
            res0      = '{EV_END, 8'd0, KIND_COMMAND, 4'd0, 1'b1};
            res_cnt   = 2'd1;
            phase_nxt = PH_PARAM;
          end else begin
            res0      = '{EV_DATA, rx_byte, KIND_COMMAND, 4'd0, 1'b1};
            res_cnt   = 2'd1;
            phase_nxt = PH_COMMAND;
            fopen_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      pcnt_r  <= 4'd0;
      fopen_r <= 1'b0;
    end else if (commit) begin
      phase_r <= phase_nxt;
      pcnt_r  <= pcnt_nxt;
      fopen_r <= fopen_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/irc_tok_outq.sv
// ----------------------------------------------------------------------------
// IRC tokenizer result buffer
// Two-entry holding register; takes one or two results, hands them out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module irc_tok_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic [1:0]        load_cnt,
  input  wire irc_tok_pkg::res_t load_res0,
  input  wire irc_tok_pkg::res_t load_res1,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output irc_tok_pkg::res_t      out_res
);
  import irc_tok_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  res_t       head_r, tail_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = head_r;
  assign pop       = out_valid && out_ready;
  // room once the last held result leaves this cycle
  assign can_load  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  always_comb begin
    cnt_nxt = cnt_r;
    if (load)     cnt_nxt = load_cnt;
    else if (pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head_r <= load_res0;
      tail_r <= load_res1;
    end else if (pop) begin
      head_r <= tail_r;
    end
  end

endmodule

`default_nettype wire

// File: sv/irc_line_tokenizer.sv
// Accepted bytes are held in the input register; results are registered in the result buffer.
// Throughput: one byte per cycle while the result buffer can load; a byte that ends an
//   open field at line end gives two results and holds the next byte while they drain.
// The rate is set by the single step register feeding the two-entry result buffer.
// Reset (rst_n low, synchronous): empties both stages, parser back to line start.
// ----------------------------------------------------------------------------
// IRC line tokenizer
// Input register, byte step logic with parser state, result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "irc_line_tokenizer_macros.svh"

module irc_line_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_link_closed,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_event_res,
  output logic [7:0]      out_char_out,
  output logic [1:0]      out_field_kind,
  output logic [3:0]      out_param_index,
  output logic            out_last
);
  import irc_tok_pkg::*;

  logic       item_v_r;
  logic [7:0] byte_r;
  logic       closed_r;
  logic [1:0] step_cnt;
  res_t       step_res0, step_res1, out_res;
  logic       can_load, consume, load;

  assign consume  = item_v_r && (step_cnt == 2'd0 || can_load);
  assign load     = item_v_r && step_cnt != 2'd0 && can_load;
  assign in_ready = !item_v_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n)        item_v_r <= 1'b0;
    else if (in_ready) item_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r   <= in_rx_byte;
      closed_r <= in_link_closed;
    end
  end

  irc_tok_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_byte     (byte_r),
    .link_closed (closed_r),
    .commit      (consume),
    .res_cnt     (step_cnt),
    .res0        (step_res0),
    .res1        (step_res1)
  );

  irc_tok_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_cnt  (step_cnt),
    .load_res0 (step_res0),
    .load_res1 (step_res1),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_event_res   = out_res.event_res;
  assign out_char_out    = out_res.char_out;
  assign out_field_kind  = out_res.field_kind;
  assign out_param_index = out_res.param_index;
  assign out_last        = out_res.last;

  `IRC_TOK_ASSERT_IMP(a_char_zero, out_valid && out_event_res != EV_DATA,
                      out_char_out == 8'd0, "char set on non-data result")
  `IRC_TOK_ASSERT_IMP(a_line_last,
                      out_valid && (out_event_res == EV_OK || out_event_res == EV_ERR),
                      out_last, "line event not last")
  `IRC_TOK_ASSERT_NXT(a_in_held, in_valid && in_ready, item_v_r,
                      "accepted item lost from step register")

endmodule

`default_nettype wire

// File: tb/irc_line_tokenizer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IRC line tokenizer testbench
// Feeds hand-picked bytes and then randomly built IRC lines (prefixes,
// commands, parameter lists up to overflow, trailing text, broken links and
// noise) with random sender bursts and receiver stalls. Every result item is
// checked field by field against an in-bench line parser or, for typed table rows, the table.
// ----------------------------------------------------------------------------

module irc_line_tokenizer_test;
  import irc_tok_pkg::*;

  typedef enum logic [2:0] {
    PH_LINE_START, PH_PREFIX, PH_COMMAND, PH_MIDDLE, PH_TRAIL
  } parse_phase_t;

  typedef struct {
    logic [7:0] ch;
    logic       closed;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       closed;
    logic       typed;    // results below are the expectation, not the parser's
    logic [1:0] n_typed;
    res_t       r0;
    res_t       r1;
  } dir_row_t;

  localparam res_t NO_RES       = '0;
  localparam res_t LINE_OK_RES  = '{EV_OK,  8'h00, KIND_PREFIX, 4'd0, 1'b1};
  localparam res_t LINE_ERR_RES = '{EV_ERR, 8'h00, KIND_PREFIX, 4'd0, 1'b1};
  localparam int   N_DIR        = 22;
  localparam int   N_RANDOM     = 800;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_link_closed = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_event_res;
  logic [7:0] out_char_out;
  logic [1:0] out_field_kind;
  logic [3:0] out_param_index;
  logic       out_last;

  irc_line_tokenizer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .in_link_closed (in_link_closed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_res  (out_event_res),
    .out_char_out   (out_char_out),
    .out_field_kind (out_field_kind),
    .out_param_index(out_param_index),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser state mirror
  parse_phase_t line_phase = PH_LINE_START;
  logic [3:0]   param_cnt = 4'd0;
  logic         field_has_data = 1'b0;

  res_t     token_q [$];
  res_t     want;
  rx_item_t line_q [$];
  int       n_errors = 0;
  int       n_sent = 0;
  int       n_results = 0;
  int       n_lines = 0;
  int       n_bad_lines = 0;
  int       n_saturated = 0;
  int       burst_left = 0;

  // receiver stall pattern
  int         ready_mode = 0;
  int         mode_left = 0;
  int         stall_left = 0;
  logic [7:0] rx_tick = 8'd0;

  dir_row_t dir_tbl [N_DIR] = '{
    '{CH_LF,    1'b0, 1'b1, 2'd1, LINE_OK_RES,  NO_RES},  // empty line
    '{CH_CR,    1'b0, 1'b1, 2'd0, NO_RES,       NO_RES},
    '{8'hFF,    1'b1, 1'b1, 2'd1, LINE_ERR_RES, NO_RES},  // closed at line start
    '{CH_COLON, 1'b0, 1'b1, 2'd0, NO_RES,       NO_RES},  // opens prefix silently
    '{"n",      1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},
    '{8'hFF,    1'b0, 1'b1, 2'd1, '{EV_DATA, 8'hFF, KIND_PREFIX, 4'd0, 1'b1}, NO_RES},
    '{CH_SPACE, 1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},
    '{"P",      1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},
    '{CH_SPACE, 1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},
    '{CH_SPACE, 1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},  // empty parameter
    '{"a",      1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},
    '{CH_COLON, 1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},  // discard, then trailing
    '{"x",      1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},
    '{CH_COLON, 1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},
    '{CH_CR,    1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},
    '{CH_LF,    1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},
    '{CH_SPACE, 1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},  // leading space
    '{CH_LF,    1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},
    '{8'h00,    1'b0, 1'b1, 2'd1, '{EV_DATA, 8'h00, KIND_COMMAND, 4'd0, 1'b1}, NO_RES},
    '{CH_SPACE, 1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},
    '{CH_COLON, 1'b0, 1'b0, 2'd0, NO_RES,       NO_RES},  // colon on empty parameter
    '{CH_LF,    1'b1, 1'b0, 2'd0, NO_RES,       NO_RES}   // link drop in trailing
  };

  function automatic logic [1:0] kind_for(input parse_phase_t ph);
    case (ph)
      PH_PREFIX:  return KIND_PREFIX;
      PH_COMMAND: return KIND_COMMAND;
      PH_MIDDLE:  return KIND_MIDDLE;
      default:    return KIND_TRAIL;
    endcase
  endfunction

  function automatic logic [3:0] index_for(input parse_phase_t ph);
    return (ph == PH_MIDDLE || ph == PH_TRAIL) ? param_cnt : 4'd0;
  endfunction

  // Advance the parser by one byte; queue its tokens when keep is set.
  task automatic tokenize_byte(input logic [7:0] ch, input logic closed, input bit keep);
    res_t r [0:1];
    int   n;
    n = 0;
    r[0] = NO_RES;
    r[1] = NO_RES;
    if (closed || ch == CH_LF) begin
      if (line_phase != PH_LINE_START) begin
        r[n] = '{EV_END, 8'h00, kind_for(line_phase), index_for(line_phase), 1'b0};
        n++;
      end
      r[n] = '{closed ? EV_ERR : EV_OK, 8'h00, KIND_PREFIX, 4'd0, 1'b0};
      n++;
      n_lines++;
      if (closed) n_bad_lines++;
      line_phase = PH_LINE_START;
      param_cnt = 4'd0;
      field_has_data = 1'b0;
    end else if (ch != CH_CR) begin
      case (line_phase)
        PH_PREFIX: begin
          if (ch == CH_SPACE) begin
            r[n] = '{EV_END, 8'h00, KIND_PREFIX, 4'd0, 1'b0};
            line_phase = PH_COMMAND;
            field_has_data = 1'b0;
          end else begin
            r[n] = '{EV_DATA, ch, KIND_PREFIX, 4'd0, 1'b0};
            field_has_data = 1'b1;
          end
          n++;
        end
        PH_COMMAND: begin
          if (ch == CH_SPACE) begin
            r[n] = '{EV_END, 8'h00, KIND_COMMAND, 4'd0, 1'b0};
            line_phase = PH_MIDDLE;
            param_cnt = 4'd0;
            field_has_data = 1'b0;
          end else begin
            r[n] = '{EV_DATA, ch, KIND_COMMAND, 4'd0, 1'b0};
            field_has_data = 1'b1;
          end
          n++;
        end
        PH_MIDDLE: begin
          if (ch == CH_SPACE) begin
            r[n] = '{EV_END, 8'h00, KIND_MIDDLE, param_cnt, 1'b0};
            n++;
            if (param_cnt < PARAM_CAP) param_cnt++;
            field_has_data = 1'b0;
          end else if (ch == CH_COLON) begin
            if (field_has_data) begin
              r[n] = '{EV_DISCARD, 8'h00, KIND_MIDDLE, param_cnt, 1'b0};
              n++;
            end
            line_phase = PH_TRAIL;
            field_has_data = 1'b0;
          end else begin
            r[n] = '{EV_DATA, ch, KIND_MIDDLE, param_cnt, 1'b0};
            n++;
            field_has_data = 1'b1;
          end
        end
        PH_TRAIL: begin
          r[n] = '{EV_DATA, ch, KIND_TRAIL, param_cnt, 1'b0};
          n++;
          field_has_data = 1'b1;
        end
        default: begin
          param_cnt = 4'd0;
          field_has_data = 1'b0;
          if (ch == CH_COLON) begin
            line_phase = PH_PREFIX;
          end else if (ch == CH_SPACE) begin
            r[n] = '{EV_END, 8'h00, KIND_COMMAND, 4'd0, 1'b0};
            n++;
            line_phase = PH_MIDDLE;
          end else begin
            r[n] = '{EV_DATA, ch, KIND_COMMAND, 4'd0, 1'b0};
            n++;
            line_phase = PH_COMMAND;
            field_has_data = 1'b1;
          end
        end
      endcase
    end
    if (n > 0) r[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (r[i].param_index == PARAM_CAP) n_saturated++;
      if (keep) token_q.push_back(r[i]);
    end
  endtask

  task automatic send_byte(input logic [7:0] ch, input logic closed, input bit keep);
    @(negedge clk);
    in_valid <= 1'b1;
    in_rx_byte <= ch;
    in_link_closed <= closed;
    do @(posedge clk); while (!in_ready);
    tokenize_byte(ch, closed, keep);
    n_sent++;
  endtask

  // sender burst/gap pacing
  task automatic sender_pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_rx_byte <= 8'($urandom);
      in_link_closed <= 1'($urandom);
      repeat ($urandom_range(0, 4)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t: token mismatch: %s", $time, what);
    n_errors++;
  endtask

  task automatic push_rx(input logic [7:0] ch, input logic closed);
    line_q.push_back('{ch, closed});
  endtask

  // name character: no space, colon, CR or LF; sometimes high bytes
  function automatic logic [7:0] name_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(128, 255));
    c = 8'($urandom_range(33, 126));
    return (c == CH_COLON) ? "~" : c;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom);
    return (c == CH_LF) ? 8'h0B : c;
  endfunction

  task automatic build_line();
    int sel;
    int n_par;
    int tail;
    line_q.delete();
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      repeat ($urandom_range(1, 12)) push_rx(8'($urandom), $urandom_range(0, 19) == 0);
      return;
    end
    if ($urandom_range(0, 2) == 0) begin
      push_rx(CH_COLON, 1'b0);
      repeat ($urandom_range(1, 6)) push_rx(name_char(), 1'b0);
      push_rx(CH_SPACE, 1'b0);
    end
    if ($urandom_range(0, 9) == 0) push_rx(CH_SPACE, 1'b0);  // empty command
    else repeat ($urandom_range(1, 6)) push_rx(name_char(), 1'b0);
    n_par = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 20) : $urandom_range(0, 4);
    repeat (n_par) begin
      push_rx(CH_SPACE, 1'b0);
      if ($urandom_range(0, 9) != 0)
        repeat ($urandom_range(0, 5)) push_rx(name_char(), 1'b0);
    end
    tail = $urandom_range(0, 3);
    if (tail == 1 || tail == 2) begin
      push_rx(CH_SPACE, 1'b0);
      if (tail == 2) repeat ($urandom_range(1, 3)) push_rx(name_char(), 1'b0);
      push_rx(CH_COLON, 1'b0);
      repeat ($urandom_range(0, 10)) push_rx(text_char(), 1'b0);
    end else if (tail == 3) begin
      push_rx(CH_SPACE, 1'b0);
    end
    if (sel < 20) begin
      // cut the line short by a dropped link
      while (line_q.size() > 1 && $urandom_range(0, 2) != 0) void'(line_q.pop_back());
      push_rx(8'($urandom), 1'b1);
    end else begin
      if ($urandom_range(0, 2) != 0) push_rx(CH_CR, 1'b0);
      push_rx(CH_LF, 1'b0);
    end
  endtask

  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    rx_tick <= rx_tick + 8'd1;
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom);
      2: out_ready <= (rx_tick[1:0] != 2'b00);
      default: begin
        if (stall_left != 0) begin
          out_ready <= 1'b0;
          stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
          out_ready <= 1'b0;
          stall_left <= $urandom_range(2, 7);
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = token_q.pop_front();
        n_results++;
        if (out_event_res !== want.event_res)
          report_mismatch($sformatf("event_res %0d, want %0d", out_event_res, want.event_res));
        if (out_char_out !== want.char_out)
          report_mismatch($sformatf("char_out %h, want %h", out_char_out, want.char_out));
        if (out_field_kind !== want.field_kind)
          report_mismatch($sformatf("field_kind %0d, want %0d", out_field_kind,
                                    want.field_kind));
        if (out_param_index !== want.param_index)
          report_mismatch($sformatf("param_index %0d, want %0d", out_param_index,
                                    want.param_index));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0d, want %0d", out_last, want.last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int n_counted;
    n_counted = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      send_byte(dir_tbl[i].ch, dir_tbl[i].closed, !dir_tbl[i].typed);
      if (dir_tbl[i].typed) begin
        if (dir_tbl[i].n_typed >= 2'd1) token_q.push_back(dir_tbl[i].r0);
        if (dir_tbl[i].n_typed == 2'd2) token_q.push_back(dir_tbl[i].r1);
      end
      sender_pace();
    end

    while (n_counted < N_RANDOM) begin
      build_line();
      foreach (line_q[i]) begin
        send_byte(line_q[i].ch, line_q[i].closed, 1'b1);
        if (line_q[i].closed || line_q[i].ch != CH_CR) n_counted++;
        sender_pace();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d bytes sent, %0d tokens checked over %0d lines (%0d cut by link drop)",
             n_sent, n_results, n_lines, n_bad_lines);
    $display("%0d tokens at the saturated parameter index", n_saturated);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
